>>> rtl/i2c_bus_clear_sequencer_defines.svh
// ----------------------------------------------------------------------------
// i2c_bus_clear_sequencer_defines
// Assertion macros for the bus-clear sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_CLEAR_SEQUENCER_DEFINES_SVH
`define I2C_BUS_CLEAR_SEQUENCER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define I2CBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define I2CBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/i2cbc_pkg.sv
// ----------------------------------------------------------------------------
// i2cbc_pkg
// Widths, phase codes and result type of the bus-clear sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cbc_pkg;

  localparam int unsigned HalfW    = 16;
  localparam int unsigned TimerW   = 20;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [HalfW-1:0]  HalfReset    = HalfW'(5);
  localparam logic [TimerW-1:0] TimeoutReset = TimerW'(2000);

  // Register byte addresses select on bit 2
  localparam logic RegHalf    = 1'b0;
  localparam logic RegTimeout = 1'b1;

  localparam logic [PhaseW-1:0] PhIdle      = 3'd0;
  localparam logic [PhaseW-1:0] PhRelease   = 3'd1;
  localparam logic [PhaseW-1:0] PhSclWait   = 3'd2;
  localparam logic [PhaseW-1:0] PhPulseLow  = 3'd3;
  localparam logic [PhaseW-1:0] PhPulseHigh = 3'd4;
  localparam logic [PhaseW-1:0] PhStopA     = 3'd5;
  localparam logic [PhaseW-1:0] PhStopB     = 3'd6;
  localparam logic [PhaseW-1:0] PhStopC     = 3'd7;

  typedef struct packed {
    logic scl_drive_low;
    logic sda_drive_low;
    logic busy_res;
    logic done_res;
    logic bus_ok;
    logic scl_stuck;
  } result_t;

endpackage

>>> rtl/i2c_bus_clear_sequencer.sv
// Path: an item waits in the input register; when it advances, its result is
// written to the output register, which must be free or draining for that.
// Throughput: one item per cycle unless results stall; one step per item.
// Reset: rst_ni low clears the sequencer to idle, empties both registers and
// loads half period 5 and SCL timeout 2000.
// ----------------------------------------------------------------------------
// i2c_bus_clear_sequencer
// Open-drain I2C bus-clear sequencer stepped once per input tick item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_bus_clear_sequencer_defines.svh"

module i2c_bus_clear_sequencer #(
  parameter int unsigned PULSE_COUNT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          start_req_i,
  input  logic                          force_req_i,
  input  logic                          sda_level_i,
  input  logic                          scl_level_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          scl_drive_low_o,
  output logic                          sda_drive_low_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          bus_ok_o,
  output logic                          scl_stuck_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbc_pkg::ApbAddrW-1:0] paddr,
  input  logic [i2cbc_pkg::ApbDataW-1:0] pwdata,
  output logic [i2cbc_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import i2cbc_pkg::*;

  localparam int unsigned PcW = $clog2(PULSE_COUNT + 1);

  // configuration registers
  logic [HalfW-1:0]  half_q;
  logic [TimerW-1:0] timeout_q;
  logic              cfg_wr;

  // input register
  logic in_valid_q;
  logic start_q, force_q, sda_q, scl_q;
  logic advance;

  // sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [PcW-1:0]    pulse_q, pulse_d;
  logic              stuck_q, stuck_d;
  logic              ok_q, ok_d;
  logic              forced_q, forced_d;

  logic [TimerW-1:0] timer_inc;
  logic [PcW-1:0]    pulse_inc;
  logic              half_over;
  logic              done;

  // output register
  logic    out_valid_q;
  result_t res_q, res_d;

  // --------------------------------------------------------------------------
  // APB register port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= HalfReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegHalf:    half_q    <= pwdata[HalfW-1:0];
        RegTimeout: timeout_q <= pwdata[TimerW-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegHalf:    prdata = ApbDataW'(half_q);
      RegTimeout: prdata = ApbDataW'(timeout_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: an item moves on when the result register is free or drains
  // --------------------------------------------------------------------------
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      start_q <= start_req_i;
      force_q <= force_req_i;
      sda_q   <= sda_level_i;
      scl_q   <= scl_level_i;
    end
  end

  // --------------------------------------------------------------------------
  // One sequencer step per item
  // --------------------------------------------------------------------------
  assign timer_inc = timer_q + TimerW'(1);
  assign pulse_inc = pulse_q + PcW'(1);
  assign half_over = (timer_inc >= TimerW'(half_q));

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    pulse_d  = pulse_q;
    stuck_d  = stuck_q;
    ok_d     = ok_q;
    forced_d = forced_q;
    done     = 1'b0;

    unique case (phase_q)
      PhRelease: begin
        if (half_over) begin
          timer_d = '0;
          if (!forced_q && sda_q) begin
            ok_d    = 1'b1;
            stuck_d = 1'b0;
            done    = 1'b1;
            phase_d = PhIdle;
          end else begin
            phase_d = PhSclWait;
          end
        end else begin
          timer_d = timer_inc;
        end
      end
      PhSclWait: begin
        if (scl_q) begin
          timer_d = '0;
          pulse_d = '0;
          phase_d = PhPulseLow;
        end else if (timer_q >= timeout_q) begin
          stuck_d = 1'b1;
          timer_d = '0;
          pulse_d = '0;
          phase_d = PhPulseLow;
        end else begin
          timer_d = timer_inc;
        end
      end
      PhPulseLow, PhStopA, PhStopB: begin
        if (half_over) begin
          timer_d = '0;
          phase_d = (phase_q == PhPulseLow) ? PhPulseHigh :
                    (phase_q == PhStopA)    ? PhStopB     : PhStopC;
        end else begin
          timer_d = timer_inc;
        end
      end
      PhPulseHigh: begin
        if (half_over) begin
          timer_d = '0;
          pulse_d = pulse_inc;
          phase_d = (pulse_inc >= PcW'(PULSE_COUNT)) ? PhStopA : PhPulseLow;
        end else begin
          timer_d = timer_inc;
        end
      end
      PhStopC: begin
        if (half_over) begin
          timer_d = '0;
          ok_d    = sda_q;
          done    = 1'b1;
          phase_d = PhIdle;
        end else begin
          timer_d = timer_inc;
        end
      end
      default: begin
        phase_d = PhIdle;
        if (start_q) begin
          forced_d = force_q;
          timer_d  = '0;
          pulse_d  = '0;
          stuck_d  = 1'b0;
          ok_d     = 1'b0;
          phase_d  = PhRelease;
        end
      end
    endcase

    res_d.scl_drive_low = (phase_d == PhPulseLow);
    res_d.sda_drive_low = (phase_d == PhStopA) | (phase_d == PhStopB);
    res_d.busy_res      = (phase_d != PhIdle);
    res_d.done_res      = done;
    res_d.bus_ok        = done & ok_d;
    res_d.scl_stuck     = done & stuck_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      timer_q  <= '0;
      pulse_q  <= '0;
      stuck_q  <= 1'b0;
      ok_q     <= 1'b0;
      forced_q <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      pulse_q  <= pulse_d;
      stuck_q  <= stuck_d;
      ok_q     <= ok_d;
      forced_q <= forced_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_drive_low_o = res_q.scl_drive_low;
  assign sda_drive_low_o = res_q.sda_drive_low;
  assign busy_res_o      = res_q.busy_res;
  assign done_res_o      = res_q.done_res;
  assign bus_ok_o        = res_q.bus_ok;
  assign scl_stuck_o     = res_q.scl_stuck;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `I2CBC_ASSERT(a_done_not_busy, out_valid_q && res_q.done_res |-> !res_q.busy_res,
                "done reported while still busy")
  `I2CBC_ASSERT(a_flags_need_done,
                out_valid_q && (res_q.bus_ok || res_q.scl_stuck) |-> res_q.done_res,
                "status flag without done")
  `I2CBC_ASSERT(a_lines_not_both_low,
                out_valid_q |-> !(res_q.scl_drive_low && res_q.sda_drive_low),
                "SCL and SDA driven low together")
  `I2CBC_ASSERT(a_held_item_kept, in_valid_q && !advance |=> in_valid_q,
                "stalled item dropped from input register")
  `I2CBC_ASSERT(a_pulse_bound, pulse_q <= PcW'(PULSE_COUNT),
                "pulse counter past its limit")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C bus-clear sequencer. Tick items carry
// start/force requests and sampled line levels; a step-accurate sequencer
// model predicts every result item, which is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import i2cbc_pkg::*;

  localparam int unsigned PulseCount  = 32;
  localparam int unsigned SettleTicks = 4;
  localparam int unsigned CycleLimit  = 1_200_000;

  localparam logic [ApbAddrW-1:0] AddrHalf    = ApbAddrW'({RegHalf, 2'b00});
  localparam logic [ApbAddrW-1:0] AddrTimeout = ApbAddrW'({RegTimeout, 2'b00});

  typedef struct packed {
    logic start_req;
    logic force_req;
    logic sda_level;
    logic scl_level;
  } tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic  in_valid  = 1'b0;
  logic  in_ready_o;
  tick_t cur_tick  = '0;
  logic  out_valid_o;
  logic  out_ready = 1'b0;
  logic  scl_drive_low_o, sda_drive_low_o, busy_res_o, done_res_o, bus_ok_o, scl_stuck_o;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // sequencer model state and its copy of the registers
  logic [PhaseW-1:0] seq_ph      = PhIdle;
  logic [TimerW-1:0] seq_tmr     = '0;
  logic [5:0]        seq_pulses  = '0;
  logic              seq_stuck   = 1'b0;
  logic              seq_ok      = 1'b0;
  logic              seq_forced  = 1'b0;
  logic [HalfW-1:0]  cfg_half    = HalfReset;
  logic [TimerW-1:0] cfg_timeout = TimeoutReset;

  tick_t   pending_ticks[$];
  result_t expected_results[$];

  int unsigned ticks_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fails        = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned gap_odds     = 7;
  int unsigned stall_odds   = 7;
  int unsigned cycle_count  = 0;
  int unsigned seq_done_cnt = 0;
  int unsigned seq_stuck_cnt = 0;
  int unsigned seq_ok_cnt   = 0;
  int unsigned reg_writes   = 0;

  always #1 clk_i = ~clk_i;

  i2c_bus_clear_sequencer #(
    .PULSE_COUNT(PulseCount)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .start_req_i    (cur_tick.start_req),
    .force_req_i    (cur_tick.force_req),
    .sda_level_i    (cur_tick.sda_level),
    .scl_level_i    (cur_tick.scl_level),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .scl_drive_low_o(scl_drive_low_o),
    .sda_drive_low_o(sda_drive_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .bus_ok_o       (bus_ok_o),
    .scl_stuck_o    (scl_stuck_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Advance the half-period timer; true on the tick that ends the phase.
  function automatic logic half_elapsed();
    seq_tmr = seq_tmr + 1'b1;
    if (seq_tmr >= TimerW'(cfg_half)) begin
      seq_tmr = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_sequencer(input tick_t tk, output result_t r);
    logic done;
    done = 1'b0;
    case (seq_ph)
      PhRelease: if (half_elapsed()) begin
        if (!seq_forced && tk.sda_level) begin
          seq_ok    = 1'b1;
          seq_stuck = 1'b0;
          done      = 1'b1;
          seq_ph    = PhIdle;
        end else begin
          seq_ph = PhSclWait;
        end
      end
      PhSclWait: begin
        if (tk.scl_level) begin
          seq_tmr    = '0;
          seq_pulses = '0;
          seq_ph     = PhPulseLow;
        end else if (seq_tmr >= cfg_timeout) begin
          seq_stuck  = 1'b1;
          seq_tmr    = '0;
          seq_pulses = '0;
          seq_ph     = PhPulseLow;
        end else begin
          seq_tmr = seq_tmr + 1'b1;
        end
      end
      PhPulseLow: if (half_elapsed()) seq_ph = PhPulseHigh;
      PhPulseHigh: if (half_elapsed()) begin
        seq_pulses = seq_pulses + 1'b1;
        seq_ph = (seq_pulses >= PulseCount) ? PhStopA : PhPulseLow;
      end
      PhStopA: if (half_elapsed()) seq_ph = PhStopB;
      PhStopB: if (half_elapsed()) seq_ph = PhStopC;
      PhStopC: if (half_elapsed()) begin
        seq_ok = tk.sda_level;
        done   = 1'b1;
        seq_ph = PhIdle;
      end
      default: begin
        seq_ph = PhIdle;
        if (tk.start_req) begin
          seq_forced = tk.force_req;
          seq_tmr    = '0;
          seq_pulses = '0;
          seq_stuck  = 1'b0;
          seq_ok     = 1'b0;
          seq_ph     = PhRelease;
        end
      end
    endcase
    r.scl_drive_low = (seq_ph == PhPulseLow);
    r.sda_drive_low = (seq_ph == PhStopA) || (seq_ph == PhStopB);
    r.busy_res      = (seq_ph != PhIdle);
    r.done_res      = done;
    r.bus_ok        = done & seq_ok;
    r.scl_stuck     = done & seq_stuck;
    if (done) begin
      seq_done_cnt++;
      if (seq_stuck) seq_stuck_cnt++;
      if (seq_ok) seq_ok_cnt++;
    end
  endtask

  // Tick driver: hold each item until accepted, insert random gaps.
  always @(posedge clk_i) begin : drive_ticks
    result_t want;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        step_sequencer(cur_tick, want);
        expected_results.push_back(want);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
          gap_left <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          cur_tick <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fails++;
    end
  endtask

  // Result monitor with random back-pressure bursts.
  always @(posedge clk_i) begin : collect_results
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = {scl_drive_low_o, sda_drive_low_o, busy_res_o, done_res_o, bus_ok_o,
               scl_stuck_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("scl_drive_low", want.scl_drive_low, got.scl_drive_low);
          check_field("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("bus_ok", want.bus_ok, got.bus_ok);
          check_field("scl_stuck", want.scl_stuck, got.scl_stuck);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_tick(input logic st, input logic fr, input logic sda, input logic scl);
    pending_ticks.push_back('{start_req: st, force_req: fr, sda_level: sda, scl_level: scl});
    ticks_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen < ticks_queued) @(posedge clk_i);
  endtask

  // Drain, then tick on without requests until the sequencer is back in idle.
  task automatic settle();
    wait_drained();
    while (seq_ph != PhIdle) begin
      repeat (16) push_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      wait_drained();
    end
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrHalf) cfg_half = value[HalfW-1:0];
    else cfg_timeout = value[TimerW-1:0];
    reg_writes++;
  endtask

  // Episodes: a start, SCL held low for a while, SDA biased per episode,
  // with stray requests on top that the busy sequencer must drop.
  task automatic run_episodes(input int unsigned n_ticks, input int unsigned hold_max,
                              input int unsigned len_max);
    int unsigned made;
    int unsigned len;
    int unsigned hold;
    int unsigned mode;
    logic sda;
    logic scl;
    made = 0;
    while (made < n_ticks) begin
      len  = $urandom_range(20, len_max);
      hold = $urandom_range(0, hold_max);
      mode = $urandom_range(0, 2);
      for (int unsigned t = 0; t < len; t++) begin
        case (mode)
          0: sda = ($urandom_range(0, 7) == 0);
          1: sda = ($urandom_range(0, 7) != 0);
          default: sda = 1'($urandom_range(0, 1));
        endcase
        scl = (t < hold) ? 1'b0 : ($urandom_range(0, 7) != 0);
        push_tick((t == 0) || ($urandom_range(0, 15) == 0), 1'($urandom_range(0, 1)), sda,
                  scl);
      end
      made += len;
    end
  endtask

  task automatic run_setting(input logic [ApbDataW-1:0] half, input logic [ApbDataW-1:0] tmo,
                             input int unsigned n_ticks, input int unsigned hold_max,
                             input int unsigned len_max, input int unsigned odds);
    write_reg(AddrHalf, half);
    write_reg(AddrTimeout, tmo);
    gap_odds   = odds;
    stall_odds = odds;
    run_episodes(n_ticks, hold_max, len_max);
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: stray force, quick release with requests while busy
    push_tick(1'b0, 1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) push_tick(1'b1, 1'b1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1, 1'b1);
    settle();

    // upper bits dropped by the register; zero timeout flags stuck at once
    write_reg(AddrHalf, 32'hFFFF_0001);
    write_reg(AddrTimeout, 32'h0000_0000);
    push_tick(1'b1, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1, 1'b0);
    settle();

    // forced run with SDA high, longest timeout
    write_reg(AddrTimeout, 32'hFFFF_FFFF);
    push_tick(1'b1, 1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1, 1'b1);
    settle();

    // zero half period acts as one; SCL low past a short timeout
    write_reg(AddrHalf, 32'h0000_0000);
    write_reg(AddrTimeout, 32'h0000_0003);
    push_tick(1'b1, 1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0, 1'b1);
    repeat (5) push_tick(1'b0, 1'b0, 1'b1, 1'b0);
    settle();

    run_setting(32'd1, 32'd0, 200, 8, 90, 7);
    run_setting(32'd2, 32'd2, 200, 12, 160, 3);
    run_setting(32'd3, 32'd40, 200, 80, 260, 15);
    run_setting(32'd1, 32'h000F_FFFF, 150, 30, 90, 7);
    run_setting(32'd2, 32'd17, 150, 40, 160, 5);

    // last part: no idling on either side
    run_setting(32'd1, 32'd6, 200, 20, 90, 0);

    if (expected_results.size() != 0) begin
      $error("%0d result items never arrived", expected_results.size());
      fails++;
    end
    $display("Checked %0d tick items over %0d register writes.", results_seen, reg_writes);
    $display("Sequences finished: %0d, bus released: %0d, SCL stuck: %0d.",
             seq_done_cnt, seq_ok_cnt, seq_stuck_cnt);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
